// ----- rtl/sbb_pkg.sv -----
// shared types and constants for the box blur core
package sbb_pkg;

  localparam int PIX_W    = 8;
  localparam int NUM_CH   = 4;
  localparam int CFG_IW   = 2;
  localparam int CFG_DW   = 9;
  localparam int SIZE_W   = 9;
  localparam int RADREG_W = 4;
  localparam int COORD_W  = 9;

  localparam logic KIND_STORE   = 1'b0;
  localparam logic KIND_REQUEST = 1'b1;

  typedef enum logic [CFG_IW-1:0] {
    CFG_IMAGE_WIDTH  = 2'd0,
    CFG_IMAGE_HEIGHT = 2'd1,
    CFG_BLUR_RADIUS  = 2'd2
  } cfg_idx_t;

  typedef struct packed {
    logic             kind;
    logic [7:0]       col;
    logic [7:0]       row;
    logic [PIX_W-1:0] in_red;
    logic [PIX_W-1:0] in_green;
    logic [PIX_W-1:0] in_blue;
    logic [PIX_W-1:0] in_alpha;
  } req_t;

  typedef struct packed {
    logic [PIX_W-1:0] out_red;
    logic [PIX_W-1:0] out_green;
    logic [PIX_W-1:0] out_blue;
    logic [PIX_W-1:0] out_alpha;
    logic             out_of_range;
  } res_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SETUP,
    ST_BASE,
    ST_READ,
    ST_DRAIN,
    ST_ROW_END,
    ST_V_WAIT,
    ST_V_DIV,
    ST_FINISH
  } ctrl_state_t;

  typedef struct packed {
    logic accept;
    logic calc_win;
    logic calc_base;
    logic rd_issue;
    logic row_done;
    logic v_start;
    logic res_load;
  } cmd_t;

  typedef struct packed {
    logic oor;
    logic col_last;
    logic row_last;
    logic div_busy;
    logic res_full;
  } sts_t;

endpackage

// ----- rtl/sbb_ctrl.sv -----
// sequencer for store and blur-request transactions
module sbb_ctrl
  import sbb_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  input  logic in_kind,
  output logic in_stall,
  input  sts_t sts,
  output cmd_t cmd
);

  ctrl_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_stall = (state_r != ST_IDLE);

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid && in_kind == KIND_REQUEST) state_nxt = ST_SETUP;
      end
      ST_SETUP:   state_nxt = ST_BASE;
      ST_BASE:    state_nxt = sts.oor ? ST_FINISH : ST_READ;
      ST_READ: begin
        if (sts.col_last) state_nxt = ST_DRAIN;
      end
      ST_DRAIN:   state_nxt = ST_ROW_END;
      ST_ROW_END: begin
        if (!sts.div_busy) state_nxt = sts.row_last ? ST_V_WAIT : ST_READ;
      end
      ST_V_WAIT: begin
        if (!sts.div_busy) state_nxt = ST_V_DIV;
      end
      ST_V_DIV: begin
        if (!sts.div_busy) state_nxt = ST_FINISH;
      end
      ST_FINISH: begin
        if (!sts.res_full) state_nxt = ST_IDLE;
      end
      default:    state_nxt = ST_IDLE;
    endcase
  end

  // commands; the window is captured while the request is still on the input
  always_comb begin
    cmd = '0;
    unique case (state_r)
      ST_IDLE: begin
        cmd.accept   = in_valid;
        cmd.calc_win = in_valid && in_kind == KIND_REQUEST;
      end
      ST_BASE:    cmd.calc_base = !sts.oor;
      ST_READ:    cmd.rd_issue  = 1'b1;
      ST_ROW_END: cmd.row_done  = !sts.div_busy;
      ST_V_WAIT:  cmd.v_start   = !sts.div_busy;
      ST_FINISH:  cmd.res_load  = !sts.res_full;
      default:    cmd = '0;
    endcase
  end

  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.res_load |-> !sts.res_full)
    else $error("result loaded over a pending result");

  a_div_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.row_done || cmd.v_start) |-> !sts.div_busy)
    else $error("division started while divider busy");

  a_div_runs: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.row_done || cmd.v_start) |=> sts.div_busy)
    else $error("divider did not start");

  a_read_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.rd_issue && sts.col_last) |=> !cmd.rd_issue)
    else $error("read past end of row window");

endmodule

// ----- rtl/sbb_datapath.sv -----
// frame store, window counters, channel accumulators, dividers and result register
module sbb_datapath
  import sbb_pkg::*;
#(
  parameter int MAX_WIDTH  = 256,
  parameter int MAX_HEIGHT = 256,
  parameter int MAX_RADIUS = 15
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  cmd_t                            cmd,
  output sts_t                            sts,
  input  req_t                            req,
  input  logic [SIZE_W-1:0]               w_eff,
  input  logic [SIZE_W-1:0]               h_eff,
  input  logic [$clog2(MAX_RADIUS+1)-1:0] r_eff,
  output logic                            out_valid,
  input  logic                            out_stall,
  output res_t                            out_data
);

  localparam int RW    = $clog2(MAX_RADIUS + 1);
  localparam int CW    = $clog2(2 * MAX_RADIUS + 2);
  localparam int SW    = PIX_W + CW;
  localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int STW   = $clog2(PIX_W);
  localparam int WW    = COORD_W + 1;

  // frame store
  logic [NUM_CH*PIX_W-1:0] mem [DEPTH];
  logic [NUM_CH*PIX_W-1:0] rd_data_r;
  logic                    wr_en;
  logic [AW-1:0]           wr_addr;

  // window
  logic                 oor_r;
  logic [COORD_W-1:0]   x0_r, x1_r, y0_r, y1_r, x_r, y_r;
  logic [CW-1:0]        hcnt_r, vcnt_r;
  logic [AW-1:0]        addr_r, row_base_r, base_nxt;
  logic [WW-1:0]        xlo, xhi, ylo, yhi, xsum, ysum, xlim, ylim;

  // accumulation and division
  logic             rd_pend_r;
  logic [SW-1:0]    hsum_r [NUM_CH];
  logic [SW-1:0]    vsum_r [NUM_CH];
  logic [SW-1:0]    rem_r  [NUM_CH];
  logic [PIX_W-1:0] quo_r  [NUM_CH];
  logic [NUM_CH-1:0] ge;
  logic [SW-1:0]    dsr_r;
  logic [STW-1:0]   step_r;
  logic             busy_r, done_r, mode_v_r;
  logic             start;

  assign wr_en = cmd.accept && req.kind == KIND_STORE
                 && ({1'b0, req.col} < w_eff) && ({1'b0, req.row} < h_eff);
  assign wr_addr = AW'(req.row) * AW'(MAX_WIDTH) + AW'(req.col);

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= {req.in_alpha, req.in_blue, req.in_green, req.in_red};
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rd_issue) begin
      rd_data_r <= mem[addr_r];
    end
  end

  // clipped window bounds
  always_comb begin
    xsum = WW'(req.col) + WW'(r_eff);
    ysum = WW'(req.row) + WW'(r_eff);
    xlim = WW'(w_eff) - WW'(1);
    ylim = WW'(h_eff) - WW'(1);
    xlo  = (WW'(req.col) > WW'(r_eff)) ? WW'(req.col) - WW'(r_eff) : '0;
    ylo  = (WW'(req.row) > WW'(r_eff)) ? WW'(req.row) - WW'(r_eff) : '0;
    xhi  = (xsum > xlim) ? xlim : xsum;
    yhi  = (ysum > ylim) ? ylim : ysum;
    base_nxt = AW'(y0_r) * AW'(MAX_WIDTH);
  end

  always_ff @(posedge clk) begin
    if (cmd.calc_win) begin
      oor_r <= ({1'b0, req.col} >= w_eff) || ({1'b0, req.row} >= h_eff);
      x0_r  <= COORD_W'(xlo);
      x1_r  <= COORD_W'(xhi);
      y0_r  <= COORD_W'(ylo);
      y1_r  <= COORD_W'(yhi);
    end
    if (cmd.calc_base) begin
      hcnt_r     <= CW'(x1_r - x0_r + COORD_W'(1));
      vcnt_r     <= CW'(y1_r - y0_r + COORD_W'(1));
      row_base_r <= base_nxt;
      addr_r     <= base_nxt + AW'(x0_r);
      x_r        <= x0_r;
      y_r        <= y0_r;
    end else if (cmd.rd_issue) begin
      addr_r <= addr_r + AW'(1);
      x_r    <= x_r + COORD_W'(1);
    end else if (cmd.row_done) begin
      row_base_r <= row_base_r + AW'(MAX_WIDTH);
      addr_r     <= row_base_r + AW'(MAX_WIDTH) + AW'(x0_r);
      x_r        <= x0_r;
      y_r        <= y_r + COORD_W'(1);
    end
  end

  // divider control
  assign start = cmd.row_done || cmd.v_start;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_pend_r <= 1'b0;
      busy_r    <= 1'b0;
      done_r    <= 1'b0;
      mode_v_r  <= 1'b0;
      step_r    <= '0;
    end else begin
      rd_pend_r <= cmd.rd_issue;
      done_r    <= busy_r && step_r == '0;
      if (start) begin
        busy_r   <= 1'b1;
        mode_v_r <= cmd.v_start;
        step_r   <= STW'(PIX_W - 1);
      end else if (busy_r) begin
        step_r <= step_r - STW'(1);
        if (step_r == '0) busy_r <= 1'b0;
      end
    end
  end

  always_comb begin
    for (int i = 0; i < NUM_CH; i++) begin
      ge[i] = (rem_r[i] >= dsr_r);
    end
  end

  // per-channel lanes: accumulate, restoring division one quotient bit a cycle
  always_ff @(posedge clk) begin
    if (start) begin
      dsr_r <= SW'(cmd.v_start ? vcnt_r : hcnt_r) << (PIX_W - 1);
    end else if (busy_r) begin
      dsr_r <= dsr_r >> 1;
    end
    for (int i = 0; i < NUM_CH; i++) begin
      if (cmd.calc_base || cmd.row_done) begin
        hsum_r[i] <= '0;
      end else if (rd_pend_r) begin
        hsum_r[i] <= hsum_r[i] + SW'(rd_data_r[PIX_W*i +: PIX_W]);
      end
      if (cmd.calc_base) begin
        vsum_r[i] <= '0;
      end else if (done_r && !mode_v_r) begin
        vsum_r[i] <= vsum_r[i] + SW'(quo_r[i]);
      end
      if (start) begin
        rem_r[i] <= cmd.v_start ? vsum_r[i] : hsum_r[i];
        quo_r[i] <= '0;
      end else if (busy_r) begin
        if (ge[i]) rem_r[i] <= rem_r[i] - dsr_r;
        quo_r[i] <= {quo_r[i][PIX_W-2:0], ge[i]};
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else if (cmd.res_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.res_load) begin
      out_data.out_red      <= oor_r ? '0 : quo_r[0];
      out_data.out_green    <= oor_r ? '0 : quo_r[1];
      out_data.out_blue     <= oor_r ? '0 : quo_r[2];
      out_data.out_alpha    <= oor_r ? '0 : quo_r[3];
      out_data.out_of_range <= oor_r;
    end
  end

  assign sts.oor      = oor_r;
  assign sts.col_last = (x_r == x1_r);
  assign sts.row_last = (y_r == y1_r);
  assign sts.div_busy = busy_r || done_r;
  assign sts.res_full = out_valid && out_stall;

endmodule

// ----- rtl/separable_box_blur_rgba8_core.sv -----
// box blur core top level: configuration registers, sequencer and datapath
// store transaction: accepted while idle, written to the frame store at its accepting edge
// request: each row of the clipped window is read through the single read port, and its
//   sum is divided by the 8-step divider while the next row is read; a final division
//   of the row means gives the result; out-of-range request: loaded without any read
// one transaction at a time, the next accepted in the cycle after its result loads
// sync active-low reset clears control, loads defaults 256/256/3; frame store not cleared
module separable_box_blur_rgba8_core
  import sbb_pkg::*;
#(
  parameter int MAX_WIDTH  = 256,
  parameter int MAX_HEIGHT = 256,
  parameter int MAX_RADIUS = 15
) (
  input  logic              clk,
  input  logic              rst_n,
  // input transactions
  input  logic              in_valid,
  output logic              in_stall,
  input  req_t              in_data,
  // result transactions
  output logic              out_valid,
  input  logic              out_stall,
  output res_t              out_data,
  // register writes
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [CFG_IW-1:0] cfg_index,
  input  logic [CFG_DW-1:0] cfg_data
);

  localparam int RW = $clog2(MAX_RADIUS + 1);

  logic [SIZE_W-1:0]   width_r, height_r;
  logic [RADREG_W-1:0] radius_r;
  logic [SIZE_W-1:0]   w_eff, h_eff;
  logic [RW-1:0]       r_eff;
  cmd_t                cmd;
  sts_t                sts;

  // register port never back-pressures
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= SIZE_W'(256);
      height_r <= SIZE_W'(256);
      radius_r <= RADREG_W'(3);
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_IMAGE_WIDTH:  width_r  <= cfg_data;
        CFG_IMAGE_HEIGHT: height_r <= cfg_data;
        CFG_BLUR_RADIUS:  radius_r <= cfg_data[RADREG_W-1:0];
        default:          ; // unused index, write dropped
      endcase
    end
  end

  // zero size acts as one, oversize saturates at the frame store limits
  always_comb begin
    if (width_r == '0)                      w_eff = SIZE_W'(1);
    else if (13'(width_r) > 13'(MAX_WIDTH)) w_eff = SIZE_W'(MAX_WIDTH);
    else                                    w_eff = width_r;
    if (height_r == '0)                       h_eff = SIZE_W'(1);
    else if (13'(height_r) > 13'(MAX_HEIGHT)) h_eff = SIZE_W'(MAX_HEIGHT);
    else                                      h_eff = height_r;
    // radius saturates at the largest supported window
    r_eff = (7'(radius_r) > 7'(MAX_RADIUS)) ? RW'(MAX_RADIUS) : RW'(radius_r);
  end

  sbb_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_kind  (in_data.kind),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  sbb_datapath #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT),
    .MAX_RADIUS (MAX_RADIUS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .sts       (sts),
    .req       (in_data),
    .w_eff     (w_eff),
    .h_eff     (h_eff),
    .r_eff     (r_eff),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

// ----- test/blur_checker.sv -----
// result checker for the box blur core: mirrors registers and frame store, predicts, compares
`timescale 1ns / 1ps
module blur_checker
  import sbb_pkg::*;
#(
  parameter int MAX_WIDTH  = 256,
  parameter int MAX_HEIGHT = 256,
  parameter int MAX_RADIUS = 15
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_stall,
  input  req_t              in_data,
  input  logic              out_valid,
  input  logic              out_stall,
  input  res_t              out_data,
  input  logic              cfg_valid,
  input  logic              cfg_ready,
  input  logic [CFG_IW-1:0] cfg_index,
  input  logic [CFG_DW-1:0] cfg_data,
  output int                mismatches,
  output int                awaiting
);

  localparam int REPORT_MAX = 10;

  logic [SIZE_W-1:0]            width_reg;
  logic [SIZE_W-1:0]            height_reg;
  logic [RADREG_W-1:0]          radius_reg;
  logic [NUM_CH-1:0][PIX_W-1:0] frame_copy [MAX_WIDTH*MAX_HEIGHT];
  res_t                         pending_pixels [$];
  int                           bad_count = 0;

  // zero acts as one, anything above the maximum saturates
  function automatic int clamp_size(input logic [SIZE_W-1:0] v, input int lim);
    if (v == 0) return 1;
    if (v > lim) return lim;
    return int'(v);
  endfunction

  // horizontal truncated mean per row, then truncated mean of those down the window
  function automatic res_t blurred_pixel(input logic [7:0] c, input logic [7:0] r);
    int w, h, rad, x0, x1, y0, y1, x, y, ch;
    int hsum [NUM_CH];
    int vsum [NUM_CH];
    logic [NUM_CH-1:0][PIX_W-1:0] px;
    res_t res;
    w = clamp_size(width_reg, MAX_WIDTH);
    h = clamp_size(height_reg, MAX_HEIGHT);
    rad = (radius_reg > MAX_RADIUS) ? MAX_RADIUS : int'(radius_reg);
    res = '0;
    if (c >= w || r >= h) begin
      res.out_of_range = 1'b1;
      return res;
    end
    x0 = (c > rad) ? c - rad : 0;
    x1 = (c + rad > w - 1) ? w - 1 : c + rad;
    y0 = (r > rad) ? r - rad : 0;
    y1 = (r + rad > h - 1) ? h - 1 : r + rad;
    for (ch = 0; ch < NUM_CH; ch++) vsum[ch] = 0;
    for (y = y0; y <= y1; y++) begin
      for (ch = 0; ch < NUM_CH; ch++) hsum[ch] = 0;
      for (x = x0; x <= x1; x++) begin
        px = frame_copy[y*MAX_WIDTH + x];
        for (ch = 0; ch < NUM_CH; ch++) hsum[ch] += px[ch];
      end
      for (ch = 0; ch < NUM_CH; ch++) vsum[ch] += hsum[ch] / (x1 - x0 + 1);
    end
    res.out_red   = PIX_W'(vsum[0] / (y1 - y0 + 1));
    res.out_green = PIX_W'(vsum[1] / (y1 - y0 + 1));
    res.out_blue  = PIX_W'(vsum[2] / (y1 - y0 + 1));
    res.out_alpha = PIX_W'(vsum[3] / (y1 - y0 + 1));
    return res;
  endfunction

  always @(posedge clk) begin
    res_t want;
    if (!rst_n) begin
      width_reg  = 9'd256;
      height_reg = 9'd256;
      radius_reg = 4'd3;
      pending_pixels.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_IMAGE_WIDTH:  width_reg = cfg_data;
          CFG_IMAGE_HEIGHT: height_reg = cfg_data;
          CFG_BLUR_RADIUS:  radius_reg = cfg_data[RADREG_W-1:0];
          default: ;
        endcase
      end
      if (out_valid && !out_stall) begin
        if (pending_pixels.size() == 0) begin
          bad_count++;
          if (bad_count <= REPORT_MAX)
            $display("unexpected result: rgba %0d %0d %0d %0d oor %0b",
                     out_data.out_red, out_data.out_green, out_data.out_blue,
                     out_data.out_alpha, out_data.out_of_range);
        end else begin
          want = pending_pixels.pop_front();
          if (out_data.out_red !== want.out_red || out_data.out_green !== want.out_green ||
              out_data.out_blue !== want.out_blue || out_data.out_alpha !== want.out_alpha ||
              out_data.out_of_range !== want.out_of_range) begin
            bad_count++;
            if (bad_count <= REPORT_MAX)
              $display("mismatch: expected rgba %0d %0d %0d %0d oor %0b, got %0d %0d %0d %0d oor %0b",
                       want.out_red, want.out_green, want.out_blue, want.out_alpha,
                       want.out_of_range, out_data.out_red, out_data.out_green,
                       out_data.out_blue, out_data.out_alpha, out_data.out_of_range);
          end
        end
      end
      if (in_valid && !in_stall) begin
        if (in_data.kind == KIND_REQUEST)
          pending_pixels.push_back(blurred_pixel(in_data.col, in_data.row));
        else if (in_data.col < clamp_size(width_reg, MAX_WIDTH) &&
                 in_data.row < clamp_size(height_reg, MAX_HEIGHT))
          frame_copy[in_data.row*MAX_WIDTH + in_data.col] =
            {in_data.in_alpha, in_data.in_blue, in_data.in_green, in_data.in_red};
      end
    end
    mismatches <= bad_count;
    awaiting   <= pending_pixels.size();
  end

endmodule

// ----- test/separable_box_blur_rgba8_core_tb.sv -----
// testbench top for the box blur core: stimulus, handshake pacing and verdict
`timescale 1ns / 1ps
module separable_box_blur_rgba8_core_tb;
  import sbb_pkg::*;

  // index past the register list, writes to it must be dropped
  localparam logic [CFG_IW-1:0] CFG_SPARE_IDX = 2'd3;

  localparam int FRAME_W      = 256;
  localparam int FRAME_H      = 256;
  localparam int RADIUS_MAX   = 15;
  localparam int IDLE_MAX     = 16;
  // a store lands at its accepting edge, so a short pause covers it
  localparam int STORE_SETTLE = 16;
  // longest request with a full 24x24 window plus some margin
  localparam int DRAIN_CYCLES = 1200;
  localparam int ITEM_TARGET  = 1450;
  // side of the region that random coordinates are drawn from in a large image
  localparam int SPAN         = 12;
  localparam int SMALL_SIDE   = 24;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_stall;
  req_t              in_data = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  res_t              out_data;
  logic              cfg_valid = 1'b0;
  logic              cfg_ready;
  logic [CFG_IW-1:0] cfg_index = '0;
  logic [CFG_DW-1:0] cfg_data = '0;

  int mismatches;
  int awaiting;

  // pixels the block holds a known value for; requests never touch anything else
  bit written [FRAME_W*FRAME_H];
  // current effective image size and radius, used to pick coordinates
  int eff_w = 256;
  int eff_h = 256;
  int eff_r = 3;
  // no idling on either side while set
  bit quiet = 1'b0;
  int n_items = 0;
  int n_blur = 0;
  int n_oor = 0;
  int n_settings = 0;

  always #2 clk = ~clk;

  separable_box_blur_rgba8_core #(
    .MAX_WIDTH (FRAME_W),
    .MAX_HEIGHT(FRAME_H),
    .MAX_RADIUS(RADIUS_MAX)
  ) uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  blur_checker #(
    .MAX_WIDTH (FRAME_W),
    .MAX_HEIGHT(FRAME_H),
    .MAX_RADIUS(RADIUS_MAX)
  ) blur_chk (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .mismatches(mismatches),
    .awaiting  (awaiting)
  );

  // mostly random pixels, with all-zero and all-one pixels mixed in
  function automatic logic [31:0] draw_pixel();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return '1;
      default: return $urandom();
    endcase
  endfunction

  // size register value: mostly small, sometimes full, zero or beyond the maximum
  function automatic logic [CFG_DW-1:0] draw_size();
    case ($urandom_range(0, 9))
      0: return CFG_DW'(1);
      1: return ($urandom_range(0, 1) == 0) ? '0
                : CFG_DW'($urandom_range(FRAME_W + 1, (1 << CFG_DW) - 1));
      2: return CFG_DW'(FRAME_W);
      3: return CFG_DW'($urandom_range(SMALL_SIDE + 1, FRAME_W - 1));
      default: return CFG_DW'($urandom_range(2, SMALL_SIDE));
    endcase
  endfunction

  // one input transaction; valid stays high into the next one when there is no gap
  task automatic send_item(input logic kind, input int c, input int r, input logic [31:0] px);
    req_t it;
    int gap;
    bit in_img;
    it.kind     = kind;
    it.col      = c[7:0];
    it.row      = r[7:0];
    it.in_red   = px[7:0];
    it.in_green = px[15:8];
    it.in_blue  = px[23:16];
    it.in_alpha = px[31:24];
    gap = quiet ? 0 : $urandom_range(0, IDLE_MAX);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (in_stall);
    in_img = (c < eff_w) && (r < eff_h);
    if (kind == KIND_STORE && in_img) written[r*FRAME_W + c] = 1'b1;
    // stores outside the image are dropped by the block and not counted
    if (kind == KIND_REQUEST || in_img) n_items++;
    if (kind == KIND_REQUEST) begin
      if (in_img) n_blur++;
      else n_oor++;
    end
  endtask

  // fill any unknown pixel of the clipped window first, then ask for the blur
  task automatic blur_request(input int c, input int r);
    int x0, x1, y0, y1, x, y;
    x0 = (c > eff_r) ? c - eff_r : 0;
    x1 = (c + eff_r < eff_w) ? c + eff_r : eff_w - 1;
    y0 = (r > eff_r) ? r - eff_r : 0;
    y1 = (r + eff_r < eff_h) ? r + eff_r : eff_h - 1;
    for (y = y0; y <= y1; y++)
      for (x = x0; x <= x1; x++)
        if (!written[y*FRAME_W + x]) send_item(KIND_STORE, x, y, draw_pixel());
    send_item(KIND_REQUEST, c, r, draw_pixel());
  endtask

  // transaction aimed outside the image; falls back to a normal one on a full frame
  task automatic stray_item(input logic kind, input int c, input int r);
    int sc, sr;
    sc = c;
    sr = r;
    case ($urandom_range(0, 2))
      0: if (eff_w < FRAME_W) sc = $urandom_range(eff_w, FRAME_W - 1);
      1: if (eff_h < FRAME_H) sr = $urandom_range(eff_h, FRAME_H - 1);
      default: begin
        if (eff_w < FRAME_W) sc = $urandom_range(eff_w, FRAME_W - 1);
        if (eff_h < FRAME_H) sr = $urandom_range(eff_h, FRAME_H - 1);
      end
    endcase
    if (sc < eff_w && sr < eff_h && kind == KIND_REQUEST) blur_request(sc, sr);
    else send_item(kind, sc, sr, draw_pixel());
  endtask

  // drop valid, let every pending result come back, then let a last store settle
  task automatic wait_idle();
    in_valid <= 1'b0;
    do @(posedge clk); while (awaiting != 0);
    repeat (STORE_SETTLE) @(posedge clk);
  endtask

  // leaves cfg_valid high so back-to-back writes need no extra nonblocking update
  task automatic write_reg(input logic [CFG_IW-1:0] idx, input logic [CFG_DW-1:0] v);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic set_config(input logic [CFG_DW-1:0] w, input logic [CFG_DW-1:0] h,
                            input logic [RADREG_W-1:0] rad);
    logic [CFG_DW-RADREG_W-1:0] pad;
    pad = (CFG_DW-RADREG_W)'($urandom());
    wait_idle();
    if ($urandom_range(0, 3) == 0) write_reg(CFG_SPARE_IDX, CFG_DW'($urandom()));
    write_reg(CFG_IMAGE_WIDTH, w);
    write_reg(CFG_IMAGE_HEIGHT, h);
    // bits above the radius field are junk the block must mask
    write_reg(CFG_BLUR_RADIUS, {pad, rad});
    cfg_valid <= 1'b0;
    eff_w = (w == 0) ? 1 : (w > FRAME_W) ? FRAME_W : int'(w);
    eff_h = (h == 0) ? 1 : (h > FRAME_H) ? FRAME_H : int'(h);
    eff_r = rad;
    n_settings++;
  endtask

  // one register setting followed by a mix of stores, blurs and stray transactions
  task automatic random_phase();
    logic [CFG_DW-1:0] w, h;
    logic [RADREG_W-1:0] rad;
    int fx0, fy0, fw, fh, c, r, sel;
    w = draw_size();
    h = draw_size();
    // wide radii only on small images so window fills stay cheap
    if (w <= SMALL_SIDE && h <= SMALL_SIDE)
      rad = ($urandom_range(0, 3) == 0) ? RADREG_W'(RADIUS_MAX)
            : RADREG_W'($urandom_range(0, RADIUS_MAX));
    else
      rad = RADREG_W'($urandom_range(0, 3));
    set_config(w, h, rad);
    quiet = ($urandom_range(0, 3) == 0);
    fw = (eff_w < SPAN) ? eff_w : SPAN;
    fh = (eff_h < SPAN) ? eff_h : SPAN;
    fx0 = $urandom_range(0, eff_w - fw);
    fy0 = $urandom_range(0, eff_h - fh);
    repeat ($urandom_range(20, 60)) begin
      c = fx0 + $urandom_range(0, fw - 1);
      r = fy0 + $urandom_range(0, fh - 1);
      sel = $urandom_range(0, 99);
      if (sel < 35) send_item(KIND_STORE, c, r, draw_pixel());
      else if (sel < 45) stray_item(KIND_STORE, c, r);
      else if (sel < 90) blur_request(c, r);
      else stray_item(KIND_REQUEST, c, r);
    end
  endtask

  // result side: a fresh random hold-off before each result, none in quiet phases
  initial begin
    int hold;
    forever begin
      hold = quiet ? 0 : $urandom_range(0, IDLE_MAX);
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
    end
  end

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // full frame through a saturating width value, radius zero: corners read back as stored
    set_config(9'h1FF, 9'd256, 4'd0);
    send_item(KIND_STORE, 0, 0, 32'h0000_0000);
    send_item(KIND_STORE, 255, 255, 32'hFFFF_FFFF);
    send_item(KIND_STORE, 255, 0, 32'hA5C3_3C5A);
    send_item(KIND_STORE, 0, 255, 32'h5A3C_C3A5);
    send_item(KIND_STORE, 5, 5, 32'h1234_5678);
    send_item(KIND_REQUEST, 0, 0, 32'hFFFF_FFFF);
    send_item(KIND_REQUEST, 255, 255, 32'h0000_0000);
    send_item(KIND_REQUEST, 255, 0, draw_pixel());
    send_item(KIND_REQUEST, 0, 255, draw_pixel());

    // zero sizes act as a single pixel; widest radius clips down to it
    set_config(9'd0, 9'd0, 4'd15);
    send_item(KIND_STORE, 5, 5, 32'h9E37_79B9);
    send_item(KIND_STORE, 0, 0, 32'h8040_2010);
    send_item(KIND_REQUEST, 0, 0, draw_pixel());
    send_item(KIND_REQUEST, 1, 0, draw_pixel());
    send_item(KIND_REQUEST, 0, 1, draw_pixel());
    send_item(KIND_REQUEST, 255, 255, draw_pixel());

    // back to a full frame: the dropped store must not have touched (5,5)
    set_config(9'd256, 9'd256, 4'd0);
    send_item(KIND_REQUEST, 5, 5, draw_pixel());
    send_item(KIND_REQUEST, 0, 0, draw_pixel());

    while (n_items < ITEM_TARGET) random_phase();

    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("drove %0d transactions under %0d register settings", n_items, n_settings);
    $display("checked %0d blurred reads and %0d out-of-image reads", n_blur, n_oor);
    if (mismatches == 0) begin
      $display("separable_box_blur_rgba8_core_tb OK");
    end else begin
      $display("separable_box_blur_rgba8_core_tb NOT OK");
    end
    $finish;
  end

  // hang guard, far beyond the slowest legal run
  initial begin
    #30_000_000;
    $display("separable_box_blur_rgba8_core_tb NOT OK");
    $finish;
  end

endmodule
